@@ rtl/sawq_pkg.sv @@
// Package: shared types, constants and codes for the slot allocator.
`default_nettype none
package sawq_pkg;
    localparam int MaxRowsDef   = 4;
    localparam int MaxSlotsDef  = 16;
    localparam int IdBitsDef    = 8;
    localparam int WaitDepthDef = 64;

    localparam int RowW  = 2;
    localparam int SlotW = 4;
    localparam int IdW   = 8;
    localparam int CodeW = 2;

    // reply codes
    localparam logic [CodeW-1:0] CODE_GRANT  = 2'd0;
    localparam logic [CodeW-1:0] CODE_ACK    = 2'd1;
    localparam logic [CodeW-1:0] CODE_QUEUED = 2'd2;
    localparam logic [CodeW-1:0] CODE_DROP   = 2'd3;

    // operations and kinds
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic KIND_PAIR  = 1'b1;

    // configuration register indexes
    localparam logic CFG_ROWS  = 1'b0;
    localparam logic CFG_SLOTS = 1'b1;

    // one request as it passes from front to back
    typedef struct packed {
        logic             op;
        logic             kind;
        logic [IdW-1:0]   id;
        logic [RowW-1:0]  rrow;
        logic [SlotW-1:0] rslot;
    } req_t;

    // one reply item
    typedef struct packed {
        logic             last;
        logic [SlotW-1:0] slot;
        logic [RowW-1:0]  row;
        logic             kind;
        logic [CodeW-1:0] code;
        logic [IdW-1:0]   dest;
    } reply_t;
endpackage
`default_nettype wire

@@ rtl/slot_allocator_with_wait_queues.sv @@
// Top level: slot allocator with first-fit search and per-kind wait queues.
// Usage:
//  s_ channel takes one request per handshake; s_tuser selects alloc or
//  release and single or pair. m_ channel returns one to three replies per
//  request; m_tuser gives code and kind, m_tlast marks the last one.
//  cfg channel writes rows in use (index 0) or slots per row (index 1); the
//  user writes only while idle (unenforced); free count is then rebuilt.
// Sequence: an allocation searches one row per cycle over the rows in use,
//  first fit, then replies. A release frees its slots if in range; the
//  single and the pair search for the queue heads run before its ack so
//  that m_tlast is known, and each queued grant follows the reply before
//  it. The back end takes no new request until its last reply is taken.
//  When m_tready is low the sequencer holds its reply; the front queue still
//  takes up to two more requests.
// Reset: aresetn low clears the map, empties both queues and restores
//  rows 4, slots 16; free count is then rebuilt before requests are taken.
`default_nettype none
module slot_allocator_with_wait_queues
    import sawq_pkg::*;
#(
    parameter int WAIT_DEPTH = WaitDepthDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tuser: operation, kind
    input  wire logic [1:0]  s_tuser,
    // s_tdata: requester_id[7:0], release_row[1:0], release_slot[3:0]
    input  wire logic [15:0] s_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tuser: reply_code[1:0], reply_kind
    output logic [2:0]       m_tuser,
    // m_tdata: dest_id[7:0], grant_row[1:0], grant_slot[3:0]
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);
    req_t   in_req, q_req;
    reply_t rep;
    logic   q_valid, q_ready;

    assign in_req.op    = s_tuser[0];
    assign in_req.kind  = s_tuser[1];
    assign in_req.id    = s_tdata[7:0];
    assign in_req.rrow  = s_tdata[9:8];
    assign in_req.rslot = s_tdata[13:10];
    assign cfg_ready    = 1'b1;

    sawq_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    sawq_back #(
        .WAIT_DEPTH(WAIT_DEPTH)
    ) u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
        .cfg_valid, .cfg_index, .cfg_data,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rep(rep)
    );

    assign m_tdata = {2'd0, rep.slot, rep.row, rep.dest};
    assign m_tuser = {rep.kind, rep.code};
    assign m_tlast = rep.last;
endmodule
`default_nettype wire

@@ rtl/sawq_front.sv @@
// Front end: accepts requests and holds them in a short queue for the back end.
`default_nettype none
module sawq_front
    import sawq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_req,
    output logic      out_valid,
    input  wire logic out_ready,
    output req_t      out_req
);
    // two-entry queue
    req_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= in_req;
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push not counted");
endmodule
`default_nettype wire

@@ rtl/sawq_back.sv @@
// Back end: slot map, wait queues, first-fit search and reply generation.
`default_nettype none
module sawq_back
    import sawq_pkg::*;
#(
    parameter int WAIT_DEPTH = WaitDepthDef
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire req_t       in_req,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_index,
    input  wire logic [4:0] cfg_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output reply_t          out_rep
);
    localparam int MAX_ROWS  = MaxRowsDef;
    localparam int MAX_SLOTS = MaxSlotsDef;
    localparam int ID_BITS   = IdBitsDef;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int MW = $clog2(MAX_ROWS * MAX_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_REQ, S_REL, S_ACK, S_SS, S_SG, S_PG, S_RS, S_RP, S_OUT
    } state_t;

    // slot map (flip-flops: busy bit per slot; owner ids travel in the grants)
    logic [MAX_SLOTS-1:0] busy_reg  [MAX_ROWS];
    logic [ID_BITS-1:0]   sq_mem [WAIT_DEPTH];
    logic [ID_BITS-1:0]   pq_mem [WAIT_DEPTH];
    logic [QW-1:0]        sq_head_reg, pq_head_reg;
    logic [CW-1:0]        sq_cnt_reg, pq_cnt_reg;
    logic [ID_BITS-1:0]   sq_rd_reg, pq_rd_reg;
    logic [2:0]           rows_cfg_reg;
    logic [4:0]           slots_cfg_reg;
    logic [MW-1:0]        free_reg;
    state_t               state_reg, ret_reg;
    req_t                 req_reg;
    reply_t               rep_reg;
    logic                 ovalid_reg;
    logic                 width2_reg;
    logic                 found_reg;
    logic [RW-1:0]        frow_reg;
    logic [SW-1:0]        fslot_reg;
    logic [RW:0]          srow_reg;
    logic                 pend_s_reg, pend_p_reg;
    logic [ID_BITS-1:0]   s_id_reg, p_id_reg;
    logic [RW-1:0]        s_row_reg;
    logic [SW-1:0]        s_slot_reg;

    // effective in-use area
    logic [RW:0]   nrows;
    logic [SW:0]   nslots;
    logic [MAX_SLOTS-1:0] use_mask;
    always_comb begin
        nrows = (rows_cfg_reg == 3'd0) ? (RW+1)'(1) :
                ({2'b0, rows_cfg_reg} > 5'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS)
                : (RW+1)'(rows_cfg_reg);
        nslots = (slots_cfg_reg == 5'd0) ? (SW+1)'(1) :
                 ({1'b0, slots_cfg_reg} > 6'(MAX_SLOTS)) ? (SW+1)'(MAX_SLOTS)
                 : (SW+1)'(slots_cfg_reg);
        for (int s = 0; s < MAX_SLOTS; s++)
            use_mask[s] = (s < int'(nslots));
    end

    // one row searched per cycle: priority encoder on the free vector
    logic [MAX_SLOTS-1:0] row_free, cand;
    logic                 hit;
    logic [SW-1:0]        hit_slot;
    logic [RW-1:0]        srow;
    assign srow = srow_reg[RW-1:0];
    always_comb begin
        row_free = ~busy_reg[srow] & use_mask;
        cand = width2_reg ? (row_free & (row_free >> 1) & (use_mask >> 1)) : row_free;
        hit = 1'b0;
        hit_slot = '0;
        for (int s = MAX_SLOTS - 1; s >= 0; s--)
            if (cand[s]) begin
                hit = 1'b1;
                hit_slot = SW'(s);
            end
    end

    // recount of free slots after reset or a config write: all rows in use at once
    logic [MW-1:0] free_now;
    always_comb begin
        free_now = '0;
        for (int r = 0; r < MAX_ROWS; r++)
            if (r < int'(nrows))
                free_now = free_now + MW'($countones(~busy_reg[r] & use_mask));
    end
    logic recount_reg;

    // release range check
    logic rel_ok;
    assign rel_ok = ({1'b0, req_reg.rrow} < 3'(nrows)) &&
                    ({1'b0, req_reg.rslot} + (SW+1)'(width2_reg ? 2 : 1) <= nslots);

    assign in_ready  = (state_reg == S_IDLE) && !recount_reg;
    assign out_valid = ovalid_reg;
    assign out_rep   = rep_reg;

    // queue pointer wrap at the queue depth
    function automatic logic [QW-1:0] next_ptr(input logic [QW-1:0] p);
        return (p == QW'(WAIT_DEPTH - 1)) ? '0 : QW'(p + 1'b1);
    endfunction

    function automatic logic [QW-1:0] wr_addr(input logic [QW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(c);
        if (sum >= (CW+1)'(WAIT_DEPTH)) sum = sum - (CW+1)'(WAIT_DEPTH);
        return QW'(sum);
    endfunction

    // queue read data registered
    always_ff @(posedge aclk) begin
        sq_rd_reg <= sq_mem[sq_head_reg];
        pq_rd_reg <= pq_mem[pq_head_reg];
    end

    // queue writes
    always_ff @(posedge aclk) begin
        if (state_reg == S_REQ && !found_reg && req_reg.id != 8'd0 &&
            !width2_reg && sq_cnt_reg < CW'(WAIT_DEPTH))
            sq_mem[wr_addr(sq_head_reg, sq_cnt_reg)] <= ID_BITS'(req_reg.id);
        if (state_reg == S_REQ && !found_reg && req_reg.id != 8'd0 &&
            width2_reg && pq_cnt_reg < CW'(WAIT_DEPTH))
            pq_mem[wr_addr(pq_head_reg, pq_cnt_reg)] <= ID_BITS'(req_reg.id);
    end

    function automatic reply_t mk(input logic [IdW-1:0] d, input logic [CodeW-1:0] c,
                                  input logic k, input logic [RowW-1:0] r,
                                  input logic [SlotW-1:0] s, input logic l);
        reply_t x;
        x.dest = d; x.code = c; x.kind = k; x.row = r; x.slot = s; x.last = l;
        return x;
    endfunction

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ovalid_reg    <= 1'b0;
            sq_head_reg   <= '0;
            pq_head_reg   <= '0;
            sq_cnt_reg    <= '0;
            pq_cnt_reg    <= '0;
            rows_cfg_reg  <= 3'd4;
            slots_cfg_reg <= 5'd16;
            recount_reg   <= 1'b1;
            free_reg      <= '0;
            pend_s_reg    <= 1'b0;
            pend_p_reg    <= 1'b0;
            for (int r = 0; r < MAX_ROWS; r++) busy_reg[r] <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_ROWS) rows_cfg_reg <= cfg_data[2:0];
                else                        slots_cfg_reg <= cfg_data;
                recount_reg <= 1'b1;
            end else if (recount_reg) begin
                free_reg    <= free_now;
                recount_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        req_reg    <= in_req;
                        width2_reg <= in_req.kind;
                        if (in_req.op == OP_REQUEST) begin
                            srow_reg  <= '0;
                            found_reg <= 1'b0;
                            ret_reg   <= S_REQ;
                            state_reg <= S_SEARCH;
                        end else begin
                            state_reg <= S_REL;
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        frow_reg  <= srow;
                        fslot_reg <= hit_slot;
                        state_reg <= ret_reg;
                    end else if (srow_reg + 1'b1 >= nrows) begin
                        state_reg <= ret_reg;
                    end else begin
                        srow_reg <= srow_reg + 1'b1;
                    end
                end
                S_REQ: begin
                    if (req_reg.id == 8'd0) begin
                        rep_reg <= mk(req_reg.id, CODE_DROP, req_reg.kind, '0, '0, 1'b1);
                    end else if (found_reg) begin
                        busy_reg[frow_reg][fslot_reg]  <= 1'b1;
                        if (width2_reg)
                            busy_reg[frow_reg][SW'(fslot_reg + 1'b1)]  <= 1'b1;
                        free_reg <= free_reg - (width2_reg ? MW'(2) : MW'(1));
                        rep_reg <= mk(req_reg.id, CODE_GRANT, req_reg.kind,
                                      RowW'(frow_reg), SlotW'(fslot_reg), 1'b1);
                    end else if (!width2_reg && sq_cnt_reg < CW'(WAIT_DEPTH)) begin
                        sq_cnt_reg <= sq_cnt_reg + 1'b1;
                        rep_reg <= mk(req_reg.id, CODE_QUEUED, 1'b0, '0, '0, 1'b1);
                    end else if (width2_reg && pq_cnt_reg < CW'(WAIT_DEPTH)) begin
                        pq_cnt_reg <= pq_cnt_reg + 1'b1;
                        rep_reg <= mk(req_reg.id, CODE_QUEUED, 1'b1, '0, '0, 1'b1);
                    end else begin
                        rep_reg <= mk(req_reg.id, CODE_DROP, req_reg.kind, '0, '0, 1'b1);
                    end
                    ovalid_reg <= 1'b1;
                    ret_reg    <= S_IDLE;
                    state_reg  <= S_OUT;
                end
                S_REL: begin
                    if (rel_ok) begin
                        busy_reg[RW'(req_reg.rrow)][SW'(req_reg.rslot)] <= 1'b0;
                        if (width2_reg)
                            busy_reg[RW'(req_reg.rrow)][SW'(req_reg.rslot + 1'b1)] <= 1'b0;
                        free_reg <= free_reg
                            + MW'(busy_reg[RW'(req_reg.rrow)][SW'(req_reg.rslot)])
                            + MW'(width2_reg &&
                                  busy_reg[RW'(req_reg.rrow)][SW'(req_reg.rslot + 1'b1)]);
                    end
                    state_reg <= S_ACK;
                end
                S_ACK: begin
                    // single search first
                    width2_reg <= 1'b0;
                    srow_reg   <= '0;
                    found_reg  <= 1'b0;
                    ret_reg    <= S_SG;
                    state_reg  <= (sq_cnt_reg != '0) ? S_SEARCH : S_SS;
                end
                S_SS: begin
                    state_reg <= S_SG;
                end
                S_SG: begin
                    // take the head single waiter, then search for a pair
                    pend_s_reg <= found_reg && sq_cnt_reg != '0;
                    if (found_reg && sq_cnt_reg != '0) begin
                        busy_reg[frow_reg][fslot_reg] <= 1'b1;
                        free_reg    <= free_reg - MW'(1);
                        sq_head_reg <= next_ptr(sq_head_reg);
                        sq_cnt_reg  <= sq_cnt_reg - 1'b1;
                        s_id_reg    <= sq_rd_reg;
                        s_row_reg   <= frow_reg;
                        s_slot_reg  <= fslot_reg;
                    end
                    width2_reg <= 1'b1;
                    srow_reg   <= '0;
                    found_reg  <= 1'b0;
                    ret_reg    <= S_PG;
                    state_reg  <= (pq_cnt_reg != '0) ? S_SEARCH : S_PG;
                end
                S_PG: begin
                    // take the head pair waiter; ack goes out once both outcomes are known
                    pend_p_reg <= found_reg && pq_cnt_reg != '0;
                    if (found_reg && pq_cnt_reg != '0) begin
                        busy_reg[frow_reg][fslot_reg] <= 1'b1;
                        busy_reg[frow_reg][SW'(fslot_reg + 1'b1)] <= 1'b1;
                        free_reg    <= free_reg - MW'(2);
                        pq_head_reg <= next_ptr(pq_head_reg);
                        pq_cnt_reg  <= pq_cnt_reg - 1'b1;
                        p_id_reg    <= pq_rd_reg;
                    end
                    rep_reg <= mk(req_reg.id, CODE_ACK, req_reg.kind, '0, '0,
                                  !(pend_s_reg || (found_reg && pq_cnt_reg != '0)));
                    ovalid_reg <= 1'b1;
                    ret_reg    <= S_RS;
                    state_reg  <= S_OUT;
                end
                S_RS: begin
                    // single grant reply, if any
                    if (pend_s_reg) begin
                        rep_reg <= mk(IdW'(s_id_reg), CODE_GRANT, 1'b0,
                                      RowW'(s_row_reg), SlotW'(s_slot_reg), !pend_p_reg);
                        ovalid_reg <= 1'b1;
                        pend_s_reg <= 1'b0;
                        ret_reg    <= S_RP;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_RP;
                    end
                end
                S_RP: begin
                    // pair grant reply, if any
                    if (pend_p_reg) begin
                        rep_reg <= mk(IdW'(p_id_reg), CODE_GRANT, 1'b1,
                                      RowW'(frow_reg), SlotW'(fslot_reg), 1'b1);
                        ovalid_reg <= 1'b1;
                        pend_p_reg <= 1'b0;
                        ret_reg    <= S_IDLE;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_ready) begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= ret_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !out_ready) |=> ovalid_reg)
        else $error("reply dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_cnt_reg <= CW'(WAIT_DEPTH) && pq_cnt_reg <= CW'(WAIT_DEPTH))
        else $error("wait count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !ovalid_reg)
        else $error("new request while reply pending");
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the slot allocator: self-predicting request/reply checker.
`default_nettype none
module tb
    import sawq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS  = 4;
    localparam int NSLOTS = 16;
    localparam int QDEPTH = 64;
    localparam int SETTLE = 40;

    typedef struct {
        logic [7:0] dest;
        logic [1:0] code;
        logic       kind;
        logic [1:0] row;
        logic [3:0] slot;
        logic       last;
    } reply_s;

    typedef struct {
        logic [7:0] id;
        logic       kind;
        logic [1:0] row;
        logic [3:0] slot;
    } holding_s;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [15:0] s_tdata = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ROWS;
    logic [4:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // predictor state
    logic [7:0] slot_owner [NROWS][NSLOTS];
    logic [7:0] single_waiters [$];
    logic [7:0] pair_waiters [$];
    logic [2:0] rows_reg;
    logic [4:0] slots_reg;
    reply_s     pending_replies [$];
    holding_s   holdings [$];

    int  errors = 0;
    bit  steady = 1'b0;

    always #5 aclk = ~aclk;

    slot_allocator_with_wait_queues uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    function automatic int rows_used();
        return (rows_reg < 1) ? 1 : (rows_reg > NROWS) ? NROWS : int'(rows_reg);
    endfunction

    function automatic int slots_used();
        return (slots_reg < 1) ? 1 : (slots_reg > NSLOTS) ? NSLOTS : int'(slots_reg);
    endfunction

    // first fit, row-major
    function automatic bit find_free(input int width, output int frow, output int fslot);
        frow = 0;
        fslot = 0;
        for (int r = 0; r < rows_used(); r++) begin
            for (int s = 0; s + width <= slots_used(); s++) begin
                if (slot_owner[r][s] == 0 && (width == 1 || slot_owner[r][s+1] == 0)) begin
                    frow = r;
                    fslot = s;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_reply(logic [7:0] dest, logic [1:0] code, logic kind,
                                       int row, int slot);
        reply_s e;
        e.dest = dest; e.code = code; e.kind = kind;
        e.row = row[1:0]; e.slot = slot[3:0]; e.last = 1'b0;
        pending_replies.push_back(e);
    endfunction

    function automatic void grant(logic [7:0] id, logic kind, int row, int slot);
        holding_s h;
        slot_owner[row][slot] = id;
        if (kind == KIND_PAIR) slot_owner[row][slot+1] = id;
        h.id = id; h.kind = kind; h.row = row[1:0]; h.slot = slot[3:0];
        holdings.push_back(h);
        push_reply(id, CODE_GRANT, kind, row, slot);
    endfunction

    // expected replies for one accepted request
    function automatic void predict_allocation(logic op, logic kind, logic [7:0] id,
                                               logic [1:0] rrow, logic [3:0] rslot);
        int width, frow, fslot;
        width = (kind == KIND_PAIR) ? 2 : 1;
        if (op == OP_REQUEST) begin
            if (id == 0) begin
                push_reply(id, CODE_DROP, kind, 0, 0);
            end else if (find_free(width, frow, fslot)) begin
                grant(id, kind, frow, fslot);
            end else if (kind == KIND_PAIR ? pair_waiters.size() < QDEPTH
                                           : single_waiters.size() < QDEPTH) begin
                if (kind == KIND_PAIR) pair_waiters.push_back(id);
                else single_waiters.push_back(id);
                push_reply(id, CODE_QUEUED, kind, 0, 0);
            end else begin
                push_reply(id, CODE_DROP, kind, 0, 0);
            end
        end else begin
            if (rrow < rows_used() && rslot + width <= slots_used()) begin
                for (int i = 0; i < width; i++) slot_owner[rrow][rslot+i] = '0;
            end
            push_reply(id, CODE_ACK, kind, 0, 0);
            if (single_waiters.size() > 0 && find_free(1, frow, fslot))
                grant(single_waiters.pop_front(), 1'b0, frow, fslot);
            if (pair_waiters.size() > 0 && find_free(2, frow, fslot))
                grant(pair_waiters.pop_front(), KIND_PAIR, frow, fslot);
        end
        pending_replies[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("tb: mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // reply checker
    always @(posedge aclk) begin
        reply_s e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", int'(m_tdata), -1);
            end else begin
                e = pending_replies.pop_front();
                if (m_tdata[7:0] !== e.dest) report_mismatch("dest_id", m_tdata[7:0], e.dest);
                if (m_tuser[1:0] !== e.code) report_mismatch("reply_code", m_tuser[1:0], e.code);
                if (m_tuser[2] !== e.kind) report_mismatch("reply_kind", m_tuser[2], e.kind);
                if (m_tdata[9:8] !== e.row) report_mismatch("grant_row", m_tdata[9:8], e.row);
                if (m_tdata[13:10] !== e.slot)
                    report_mismatch("grant_slot", m_tdata[13:10], e.slot);
                if (m_tdata[15:14] !== '0) report_mismatch("tdata pad", m_tdata[15:14], 0);
                if (m_tlast !== e.last) report_mismatch("tlast", m_tlast, e.last);
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
    end

    task automatic send_request(logic op, logic kind, logic [7:0] id,
                                logic [1:0] rrow, logic [3:0] rslot);
        while (!steady && $urandom_range(99) < 28) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, op};
        s_tdata  <= {2'b00, rslot, rrow, id};
        do @(posedge aclk); while (!s_tready);
        predict_allocation(op, kind, id, rrow, rslot);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [4:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_ROWS) rows_reg = value[2:0];
        else slots_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic release_held(int pick);
        holding_s h;
        h = holdings[pick];
        holdings.delete(pick);
        send_request(OP_RELEASE, h.kind, h.id, h.row, h.slot);
    endtask

    // plain grants, zero id, odd releases, head without space
    task automatic test_directed();
        send_request(OP_REQUEST, 1'b0, 8'd1, 2'd0, 4'd0);
        send_request(OP_REQUEST, KIND_PAIR, 8'd255, 2'd3, 4'd15);
        send_request(OP_REQUEST, 1'b0, 8'd0, 2'd0, 4'd0);
        send_request(OP_REQUEST, KIND_PAIR, 8'd0, 2'd0, 4'd0);
        send_request(OP_RELEASE, 1'b0, 8'd0, 2'd0, 4'd0);
        send_request(OP_RELEASE, 1'b0, 8'd9, 2'd0, 4'd0);
        send_request(OP_RELEASE, KIND_PAIR, 8'd255, 2'd3, 4'd15);
        send_request(OP_RELEASE, KIND_PAIR, 8'd255, 2'd0, 4'd1);
        send_request(OP_REQUEST, KIND_PAIR, 8'hAA, 2'd0, 4'd0);
        send_request(OP_REQUEST, 1'b0, 8'h55, 2'd0, 4'd0);
        wait_idle();
        // one slot in use: pairs can never fit
        write_register(CFG_ROWS, 5'd0);
        write_register(CFG_SLOTS, 5'd0);
        send_request(OP_REQUEST, 1'b0, 8'd7, 2'd0, 4'd0);
        send_request(OP_REQUEST, 1'b0, 8'd8, 2'd0, 4'd0);
        send_request(OP_REQUEST, KIND_PAIR, 8'd9, 2'd0, 4'd0);
        send_request(OP_RELEASE, 1'b0, 8'd7, 2'd0, 4'd0);
        send_request(OP_RELEASE, 1'b0, 8'd1, 2'd2, 4'd0);
        wait_idle();
        write_register(CFG_ROWS, 5'd7);
        write_register(CFG_SLOTS, 5'd31);
        send_request(OP_RELEASE, 1'b0, 8'd3, 2'd3, 4'd15);
        wait_idle();
    endtask

    // fill both wait queues past their depth
    task automatic test_queue_full();
        write_register(CFG_ROWS, 5'd1);
        write_register(CFG_SLOTS, 5'd1);
        for (int i = 0; i < QDEPTH + 2; i++)
            send_request(OP_REQUEST, 1'b0, 8'($urandom_range(255, 1)), 2'd0, 4'd0);
        for (int i = 0; i < QDEPTH + 2; i++)
            send_request(OP_REQUEST, KIND_PAIR, 8'($urandom_range(255, 1)), 2'd0, 4'd0);
        wait_idle();
        write_register(CFG_ROWS, 5'd4);
        write_register(CFG_SLOTS, 5'd16);
        for (int i = 0; i < 400 && (single_waiters.size() + pair_waiters.size()) > 0; i++) begin
            if (holdings.size() > 0) release_held($urandom_range(holdings.size() - 1));
            else send_request(OP_RELEASE, 1'b0, 8'd1, 2'd0, 4'd0);
        end
        wait_idle();
    endtask

    // random traffic in phases, new settings between phases
    task automatic test_random_traffic();
        int roll;
        for (int phase = 0; phase < 6; phase++) begin
            steady = (phase == 2);
            if (phase == 5) begin
                write_register(CFG_ROWS, 5'($urandom_range(7)));
                write_register(CFG_SLOTS, 5'($urandom_range(31)));
            end else begin
                write_register(CFG_ROWS, 5'($urandom_range(4, 1)));
                write_register(CFG_SLOTS, 5'($urandom_range(16, 2)));
            end
            for (int n = 0; n < 50; n++) begin
                roll = $urandom_range(99);
                if (n == 25 && phase == 3) wait_idle();
                if (roll < 52)
                    send_request(OP_REQUEST, 1'($urandom),
                                 ($urandom_range(49) == 0) ? 8'd0 : 8'($urandom_range(255, 1)),
                                 2'($urandom), 4'($urandom));
                else if (roll < 90 && holdings.size() > 0)
                    release_held($urandom_range(holdings.size() - 1));
                else
                    send_request(OP_RELEASE, 1'($urandom), 8'($urandom),
                                 2'($urandom), 4'($urandom));
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        rows_reg = 3'd4;
        slots_reg = 5'd16;
        foreach (slot_owner[r, s]) slot_owner[r][s] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);
        test_directed();
        test_queue_full();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #8ms;
        $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
